// ----- sv/mbp_pkg.sv -----
package mbp_pkg;

  localparam int unsigned ValW   = 64;
  localparam int unsigned CntW   = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PendW  = 7;
  localparam int unsigned PcntW  = 3;
  localparam int unsigned WordW  = 72;
  localparam int unsigned NbyteW = 4;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [ValW-1:0] field_value;
    logic [CntW-1:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_byte;
  } out_item_t;

  typedef struct packed {
    logic            flush;
    logic [ValW-1:0] value;
    logic [CntW-1:0] count;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_EMIT
  } back_state_e;

endpackage

// ----- sv/mbp_fifo.sv -----
module mbp_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- sv/mbp_front.sv -----
module mbp_front import mbp_pkg::*; #(
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  in_item_t req_i,
  output cmd_t     cmd_o
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FIELD_BITS);

  logic [CntW-1:0] cnt_sat;
  logic [ValW-1:0] val_mask;

  // a shift by the full width gives zero, so a count of 64 keeps every bit
  assign cnt_sat  = (req_i.bit_count > MaxCnt) ? MaxCnt : req_i.bit_count;
  assign val_mask = ~({ValW{1'b1}} << cnt_sat);

  assign cmd_o.flush = (req_i.req_type == REQ_FLUSH);
  assign cmd_o.value = req_i.field_value & val_mask;
  assign cmd_o.count = cnt_sat;

endmodule

// ----- sv/mbp_back.sv -----
module mbp_back import mbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  logic      out_full_i,
  output logic      out_push_o,
  output out_item_t res_o
);

  back_state_e       state_q, state_d;
  logic [WordW-1:0]  word_q, word_d;
  logic [CntW-1:0]   total_q, total_d;
  logic [NbyteW-1:0] nbytes_q, nbytes_d;
  logic [PendW-1:0]  pbits_q, pbits_d;
  logic [PcntW-1:0]  pcnt_q, pcnt_d;
  logic [ByteW-1:0]  flush_byte;

  // pending bits left-aligned in one byte, zero padding below
  assign flush_byte = ByteW'({1'b0, pbits_q} << (4'(ByteW) - {1'b0, pcnt_q}));

  assign res_o.out_byte  = word_q[WordW-1 -: ByteW];
  assign res_o.last_byte = (nbytes_q == NbyteW'(1));

  always_comb begin
    state_d    = state_q;
    word_d     = word_q;
    total_d    = total_q;
    nbytes_d   = nbytes_q;
    pbits_d    = pbits_q;
    pcnt_d     = pcnt_q;
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.flush) begin
            word_d  = WordW'(flush_byte);
            total_d = (pcnt_q != '0) ? CntW'(ByteW) : '0;
          end else begin
            word_d  = (WordW'(pbits_q) << cmd_i.count) | WordW'(cmd_i.value);
            total_d = CntW'(pcnt_q) + cmd_i.count;
          end
          state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // oldest bit to the top of the word, whole bytes go out from there
        word_d   = word_q << (CntW'(WordW) - total_q);
        nbytes_d = total_q[CntW-1:PcntW];
        pcnt_d   = total_q[PcntW-1:0];
        pbits_d  = word_q[PendW-1:0] & ~({PendW{1'b1}} << total_q[PcntW-1:0]);
        state_d  = (total_q[CntW-1:PcntW] != '0) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          word_d     = word_q << ByteW;
          nbytes_d   = nbytes_q - NbyteW'(1);
          if (nbytes_q == NbyteW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      nbytes_q <= '0;
      pbits_q  <= '0;
      pcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      nbytes_q <= nbytes_d;
      pbits_q  <= pbits_d;
      pcnt_q   <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    total_q <= total_d;
  end

endmodule

// ----- sv/msb_first_bit_packer.sv -----
// an accepted beat passes the command queue, the back end's load, align and emit states
//   and the result queue; one item at a time, the back end emits its n bytes (0 to 8)
//   one per cycle from the alignment register while the result queue is not full
// a two-beat command queue and a two-beat result queue let each side stall on its own
// reset: asynchronous, active low; clears pending bits, pending count and both queues
module msb_first_bit_packer import mbp_pkg::*; #(
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  req_i,
  input  logic      pop,
  output logic      empty,
  output out_item_t res_o
);

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(out_item_t);

  cmd_t      front_cmd;
  cmd_t      back_cmd;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  out_item_t back_res;

  mbp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .req_i(req_i),
    .cmd_o(front_cmd)
  );

  mbp_fifo #(
    .WIDTH(CmdW)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(front_cmd),
    .full_o (full),
    .pop_i  (cmd_pop),
    .rdata_o(back_cmd),
    .empty_o(cmd_empty)
  );

  mbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (back_cmd),
    .cmd_valid_i(!cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .out_full_i (res_full),
    .out_push_o (res_push),
    .res_o      (back_res)
  );

  mbp_fifo #(
    .WIDTH(ResW)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(back_res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_o),
    .empty_o(empty)
  );

endmodule

// ----- verif/tb_msb_first_bit_packer.sv -----
module tb_msb_first_bit_packer;
  import mbp_pkg::*;

  localparam int unsigned MaxBits     = 64;
  localparam int unsigned RandItems   = 80;
  localparam int unsigned TailItems   = 15;
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned StallLimit  = 500;
  localparam int unsigned ShowErrors  = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  req_i;
  logic      pop;
  logic      empty;
  out_item_t res_o;

  in_item_t  item_q[$];
  out_item_t exp_byte_q[$];

  logic [PendW-1:0] pend_bits;
  logic [PcntW-1:0] pend_cnt;

  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned stall_cnt;
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned flushes_sent;
  int unsigned bytes_seen;

  msb_first_bit_packer #(
    .MAX_FIELD_BITS(MaxBits)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req_i),
    .pop   (pop),
    .empty (empty),
    .res_o (res_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic in_item_t mk_item(logic req, logic [ValW-1:0] val, int unsigned cnt);
    in_item_t it;
    it.req_type    = req;
    it.field_value = val;
    it.bit_count   = CntW'(cnt);
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int unsigned pick;
    logic [ValW-1:0] val;
    int unsigned cnt;
    pick = $urandom_range(0, 99);
    val  = {$urandom, $urandom};
    if (pick < 12) begin
      return mk_item(REQ_FLUSH, val, $urandom_range(0, 127));
    end
    if (pick < 17) cnt = 0;
    else if (pick < 23) cnt = $urandom_range(MaxBits + 1, 127);
    else if (pick < 60) cnt = $urandom_range(1, 12);
    else cnt = $urandom_range(1, MaxBits);
    return mk_item(REQ_APPEND, val, cnt);
  endfunction

  // expected bytes of one accepted beat, updating the pending state
  task automatic pack_field(input in_item_t it);
    logic [ByteW-1:0] acc;
    logic [3:0]       have;
    int unsigned      cnt;
    int unsigned      n_new;
    int               i;
    out_item_t        r;
    n_new = 0;
    if (it.req_type == REQ_FLUSH) begin
      flushes_sent++;
      if (pend_cnt != 0) begin
        r.out_byte  = ByteW'({1'b0, pend_bits} << (ByteW - pend_cnt));
        r.last_byte = 1'b1;
        exp_byte_q.push_back(r);
      end
      pend_bits = '0;
      pend_cnt  = '0;
      return;
    end
    cnt  = (it.bit_count > MaxBits) ? MaxBits : it.bit_count;
    acc  = {1'b0, pend_bits};
    have = {1'b0, pend_cnt};
    for (i = int'(cnt) - 1; i >= 0; i--) begin
      acc  = {acc[ByteW-2:0], it.field_value[i]};
      have = have + 4'd1;
      if (have == ByteW) begin
        r.out_byte  = acc;
        r.last_byte = 1'b0;
        exp_byte_q.push_back(r);
        n_new++;
        acc  = '0;
        have = '0;
      end
    end
    pend_bits = acc[PendW-1:0];
    pend_cnt  = have[PcntW-1:0];
    if (n_new > 0) begin
      r = exp_byte_q.pop_back();
      r.last_byte = 1'b1;
      exp_byte_q.push_back(r);
    end
  endtask

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    bytes_seen++;
    if (exp_byte_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= ShowErrors)
        $display("unexpected beat: byte %02h last %0b", got.out_byte, got.last_byte);
      return;
    end
    want = exp_byte_q.pop_front();
    if (got.out_byte !== want.out_byte || got.last_byte !== want.last_byte) begin
      err_cnt++;
      if (err_cnt <= ShowErrors)
        $display("mismatch at byte %0d: expected %02h/%0b, got %02h/%0b", bytes_seen,
                 want.out_byte, want.last_byte, got.out_byte, got.last_byte);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        pack_field(req_i);
        items_sent++;
      end
      if (!push || !full) begin
        if (in_gap > 0) begin
          in_gap--;
          push <= 1'b0;
        end else if (item_q.size() == 0) begin
          push <= 1'b0;
        end else if (item_q.size() >= TailItems && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 2);
          push <= 1'b0;
        end else begin
          req_i <= item_q.pop_front();
          push  <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_byte(res_o);
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else if (item_q.size() >= TailItems && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= StallLimit) begin
      $display("no progress for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    req_i     = '0;
    pend_bits = '0;
    pend_cnt  = '0;
    in_gap    = 0;
    out_gap   = 0;
    stall_cnt = 0;
    err_cnt   = 0;
    items_sent   = 0;
    flushes_sent = 0;
    bytes_seen   = 0;

    // directed: zero count, empty flush, extremes, saturation, padding
    item_q.push_back(mk_item(REQ_APPEND, '1, 0));
    item_q.push_back(mk_item(REQ_FLUSH, '1, 127));
    item_q.push_back(mk_item(REQ_APPEND, '1, 64));
    item_q.push_back(mk_item(REQ_APPEND, '0, 64));
    item_q.push_back(mk_item(REQ_APPEND, 64'h5, 3));
    item_q.push_back(mk_item(REQ_FLUSH, '0, 0));
    item_q.push_back(mk_item(REQ_APPEND, 64'h55, 7));
    item_q.push_back(mk_item(REQ_APPEND, 64'h1, 1));
    item_q.push_back(mk_item(REQ_APPEND, '1, 7));
    item_q.push_back(mk_item(REQ_APPEND, 64'h0123_4567_89ab_cdef, 64));
    item_q.push_back(mk_item(REQ_APPEND, 64'hfedc_ba98_7654_3210, 127));
    item_q.push_back(mk_item(REQ_FLUSH, 64'h0, 64));
    item_q.push_back(mk_item(REQ_APPEND, 64'ha5a5_5a5a_c3c3_3c3c, 65));
    item_q.push_back(mk_item(REQ_APPEND, 64'hff, 8));
    item_q.push_back(mk_item(REQ_APPEND, 64'h00, 8));
    item_q.push_back(mk_item(REQ_APPEND, '0, 1));
    item_q.push_back(mk_item(REQ_FLUSH, '1, 127));
    item_q.push_back(mk_item(REQ_APPEND, 64'h1f, 5));
    item_q.push_back(mk_item(REQ_FLUSH, '1, 5));
    item_q.push_back(mk_item(REQ_FLUSH, '1, 5));
    item_q.push_back(mk_item(REQ_APPEND, 64'h7f, 7));
    item_q.push_back(mk_item(REQ_FLUSH, '0, 0));
    for (int n = 0; n < RandItems; n++) item_q.push_back(rand_item());

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (item_q.size() != 0 || push || exp_byte_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    err_cnt += exp_byte_q.size();

    $display("sent %0d items (%0d flushes), checked %0d output bytes, %0d errors",
             items_sent, flushes_sent, bytes_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mbp_pkg.sv
sv/mbp_fifo.sv
sv/mbp_front.sv
sv/mbp_back.sv
sv/msb_first_bit_packer.sv
verif/tb_msb_first_bit_packer.sv
